FILE: rtl/core/sspp_pkg.sv
// types, constants and helper functions shared by the servo status packet parser
package sspp_pkg;

  localparam int unsigned PARAM_DEPTH_DEF = 32;
  localparam int unsigned DECODE_BYTES    = 8;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [7:0]  SYNC_BYTE       = 8'hFF;
  localparam logic [7:0]  LEN_OVERHEAD    = 8'd2;
  localparam logic [15:0] SM_OFFSET       = 16'h0400;
  localparam int unsigned SM_SIGN_BIT     = 10;

  localparam logic [7:0]  POLL_NODE_ID_RST = 8'd1;

  // register indexes, byte address is 4 * index
  localparam logic REG_POLL_NODE_ID = 1'b0;

  typedef enum logic [2:0] {
    PH_PRE0  = 3'd0,
    PH_PRE1  = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_ERR   = 3'd4,
    PH_PARAM = 3'd5,
    PH_CSUM  = 3'd6,
    PH_DONE  = 3'd7
  } parse_phase_e;

  // one classified item between front and back
  typedef struct packed {
    logic       rearm;
    logic       is_sync;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]  node_id;
    logic [7:0]  error_status;
    logic [15:0] position;
    logic [15:0] speed;
    logic [15:0] load;
    logic [7:0]  voltage;
    logic [7:0]  temperature;
  } status_t;

  // sign-magnitude at bit 10 to two's complement, wrapped to 16 bits
  function automatic logic [15:0] sm_convert(input logic [15:0] raw);
    logic [15:0] res;
    if (raw[SM_SIGN_BIT]) begin
      res = SM_OFFSET - raw;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/sspp_front.sv
// front end: accepts stream transactions and classifies them into queue items
module sspp_front import sspp_pkg::*; (
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // rx_byte[7:0]
  input  logic       s_axis_tuser,   // req_type[0]
  input  logic       q_full_i,
  output logic       q_push_o,
  output item_t      q_item_o
);

  assign s_axis_tready = ~q_full_i;
  assign q_push_o      = s_axis_tvalid & ~q_full_i;

  always_comb begin
    q_item_o.rearm   = s_axis_tuser;
    q_item_o.is_sync = (s_axis_tdata == SYNC_BYTE);
    q_item_o.data    = s_axis_tdata;
  end

endmodule

FILE: rtl/core/sspp_queue.sv
// short fifo of classified items between front and back
module sspp_queue import sspp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  item_t         mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_pop;

  assign full_o  = (count_q == CW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/core/sspp_back.sv
// back end: packet state machine, parameter store, decode and output register
module sspp_back import sspp_pkg::*; #(
  parameter int unsigned PARAM_DEPTH = PARAM_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  input  logic [7:0]  poll_node_id_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata
);

  localparam int unsigned IW = $clog2(PARAM_DEPTH);
  localparam int unsigned SW = $clog2(DECODE_BYTES);

  parse_phase_e  phase_q, phase_d;
  logic [7:0]    sum_q, sum_d;
  logic [7:0]    count_q, count_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [7:0]    err_q, err_d;
  logic [7:0]    store_q [DECODE_BYTES];
  logic          store_we;
  logic          out_valid_q, out_valid_d;
  status_t       out_q, out_d;
  logic          pop;
  logic          match;
  logic          last_param;
  logic [7:0]    b;

  assign b          = q_item_i.data;
  assign pop        = q_valid_i & (~out_valid_q | m_axis_tready);
  assign q_pop_o    = pop;
  assign match      = (~sum_q == b);
  assign last_param = (9'(idx_q) == (9'(count_q) - 9'd1));

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (pop) begin
      if (q_item_i.rearm) begin
        phase_d = PH_PRE0;
      end else begin
        unique case (phase_q)
          PH_PRE0:  if (q_item_i.is_sync) phase_d = PH_PRE1;
          PH_PRE1:  phase_d = q_item_i.is_sync ? PH_ID : PH_PRE0;
          PH_ID:    phase_d = PH_LEN;
          PH_LEN:   phase_d = PH_ERR;
          PH_ERR:   phase_d = (count_q != '0) ? PH_PARAM : PH_CSUM;
          PH_PARAM: if (last_param) phase_d = PH_CSUM;
          PH_CSUM:  if (match) phase_d = PH_DONE;
          PH_DONE:  phase_d = PH_DONE;
          default:  phase_d = PH_PRE0;
        endcase
      end
    end
  end

  // datapath and outputs
  always_comb begin
    sum_d       = sum_q;
    count_d     = count_q;
    idx_d       = idx_q;
    err_d       = err_q;
    store_we    = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    if (pop && !q_item_i.rearm) begin
      unique case (phase_q)
        PH_ID: begin
          sum_d = b;
        end
        PH_LEN: begin
          count_d = b - LEN_OVERHEAD;
          sum_d   = sum_q + b;
        end
        PH_ERR: begin
          err_d = b;
          sum_d = sum_q + b;
          idx_d = '0;
        end
        PH_PARAM: begin
          sum_d    = sum_q + b;
          store_we = (9'(idx_q) < 9'(DECODE_BYTES));
          if (9'(idx_q) < 9'(PARAM_DEPTH - 1)) begin
            idx_d = idx_q + IW'(1);
          end
        end
        PH_CSUM: begin
          if (match) begin
            out_valid_d        = 1'b1;
            out_d.node_id      = poll_node_id_i;
            out_d.error_status = err_q;
            out_d.position     = {store_q[1], store_q[0]};
            out_d.speed        = sm_convert({store_q[3], store_q[2]});
            out_d.load         = sm_convert({store_q[5], store_q[4]});
            out_d.voltage      = store_q[6];
            out_d.temperature  = store_q[7];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PRE0;
      sum_q       <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < DECODE_BYTES; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      phase_q     <= phase_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      // only the decoded head of the store is kept, later bytes are never read
      if (store_we) begin
        store_q[idx_q[SW-1:0]] <= b;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.temperature, out_q.voltage, out_q.load, out_q.speed,
                          out_q.position, out_q.error_status, out_q.node_id};

endmodule

FILE: rtl/core/servo_status_packet_parser_unit.sv
// servo status packet parser: one byte per cycle unless the item queue is full, checksum-verified status result
// a checksum byte passes through the item queue, and its result is held in the output register
// the input takes one byte per cycle while the two-entry item queue is not full
// a result waiting in the output register does not stop the input until the queue fills
// reset: asynchronous active low, clears phase, sums, parameter store and poll_node_id to 1
// no clearing pass after reset, the block accepts transactions at once
module servo_status_packet_parser_unit import sspp_pkg::*; #(
  parameter int unsigned PARAM_DEPTH = PARAM_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  input  logic        s_axis_tuser,   // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // node_id[7:0], error_status[15:8], position[31:16], speed[47:32], load[63:48],
  // voltage[71:64], temperature[79:72]
  output logic [79:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       q_full;
  logic       q_push;
  item_t      q_in;
  logic       q_pop;
  logic       q_valid;
  item_t      q_out;
  logic [7:0] poll_node_id_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_node_id_q <= POLL_NODE_ID_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_POLL_NODE_ID)) begin
      poll_node_id_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_POLL_NODE_ID) ? {24'd0, poll_node_id_q} : 32'd0;

  sspp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in)
  );

  sspp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  sspp_back #(
    .PARAM_DEPTH (PARAM_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_out),
    .q_pop_o        (q_pop),
    .poll_node_id_i (poll_node_id_q),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata)
  );

endmodule
